// ===== src/tnfa_pkg.sv =====
// ----------------------------------------------------------------------------
// tnfa_pkg
// Shared widths, defaults and codes of the two-resource node fit allocator.
// ----------------------------------------------------------------------------
package tnfa_pkg;

    // Default sizing of the node pool
    localparam int NODES_DEF  = 128;
    localparam int CORES_DEF  = 24;
    localparam int MEMORY_DEF = 64;

    // Fixed field widths on the channels
    localparam int KIND_W   = 1;
    localparam int CORES_W  = 5;
    localparam int MEM_W    = 7;
    localparam int NODE_W   = 7;
    localparam int POLICY_W = 2;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC   = 1'b0;
    localparam logic [KIND_W-1:0] KIND_RELEASE = 1'b1;

    // Node choice rules; the fourth code selects nothing
    typedef enum logic [POLICY_W-1:0] {
        POL_FIRST = 2'd0,
        POL_BEST  = 2'd1,
        POL_WORST = 2'd2
    } policy_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_REL_RD,
        ST_REL_WR
    } state_t;

endpackage

// ===== src/tnfa_req_if.sv =====
// ----------------------------------------------------------------------------
// tnfa_req_if
// Request channel: allocate or release items with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tnfa_req_if;

    logic                          valid;
    logic                          ready;
    logic [tnfa_pkg::KIND_W-1:0]   kind;
    logic [tnfa_pkg::CORES_W-1:0]  cores_needed;
    logic [tnfa_pkg::MEM_W-1:0]    memory_needed;
    logic [tnfa_pkg::NODE_W-1:0]   release_node;

    modport source (
        output valid,
        output kind,
        output cores_needed,
        output memory_needed,
        output release_node,
        input  ready
    );

    modport sink (
        input  valid,
        input  kind,
        input  cores_needed,
        input  memory_needed,
        input  release_node,
        output ready
    );

endinterface

// ===== src/tnfa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// tnfa_rsp_if
// Response channel: one grant item per request with valid/ready handshake.
// ----------------------------------------------------------------------------
interface tnfa_rsp_if;

    logic                          valid;
    logic                          ready;
    logic                          granted;
    logic [tnfa_pkg::NODE_W-1:0]   node;
    logic [tnfa_pkg::CORES_W-1:0]  cores_left;
    logic [tnfa_pkg::MEM_W-1:0]    memory_left;

    modport source (
        output valid,
        output granted,
        output node,
        output cores_left,
        output memory_left,
        input  ready
    );

    modport sink (
        input  valid,
        input  granted,
        input  node,
        input  cores_left,
        input  memory_left,
        output ready
    );

endinterface

// ===== src/two_resource_node_fit_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// two_resource_node_fit_allocator_unit
// Node pool allocator: first, best or worst fit over free cores and memory.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake        Content
//  req       in         valid / ready    kind, cores_needed, memory_needed,
//                                        release_node
//  rsp       out        valid / ready    granted, node, cores_left, memory_left
//  cfg       in         cfg_wr_en        cfg_wr_data -> fit_policy
//
//  For an allocate item, one compare unit walks the node table one entry
//  per cycle through the registered read port of the table memory, then
//  the pick state debits the chosen node once rsp is free; then req.ready returns.
//  A release item runs through table read, saturating credit and write back.
//  After reset the table is filled with full capacity, entry by entry;
//  req.ready stays low meanwhile, config writes are taken at any time.
//  A result waits in the rsp register; the next item is taken while it waits,
//  and its own result holds back until rsp is free.
// ----------------------------------------------------------------------------
module two_resource_node_fit_allocator_unit #(
    parameter int NODES           = tnfa_pkg::NODES_DEF,
    parameter int CORES_PER_NODE  = tnfa_pkg::CORES_DEF,
    parameter int MEMORY_PER_NODE = tnfa_pkg::MEMORY_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [tnfa_pkg::POLICY_W-1:0]   cfg_wr_data,
    tnfa_req_if.sink                        req,
    tnfa_rsp_if.source                      rsp
);

    localparam int IW    = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int CNT_W = $clog2(NODES + 1);
    localparam int CW    = $clog2(CORES_PER_NODE + 1);
    localparam int MW    = $clog2(MEMORY_PER_NODE + 1);
    localparam int CXW   = (CW > tnfa_pkg::CORES_W) ? CW : tnfa_pkg::CORES_W;
    localparam int MXW   = (MW > tnfa_pkg::MEM_W) ? MW : tnfa_pkg::MEM_W;
    localparam int LW    = ((CXW > MXW) ? CXW : MXW) + 1;
    localparam int DW    = CW + MW;

    localparam logic [CW-1:0]    FULL_C    = CW'(CORES_PER_NODE);
    localparam logic [MW-1:0]    FULL_M    = MW'(MEMORY_PER_NODE);
    localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(NODES - 1);
    localparam logic [CNT_W-1:0] CNT_END   = CNT_W'(NODES);
    localparam logic [CXW:0]     CAP_C_EXT = (CXW + 1)'(CORES_PER_NODE);
    localparam logic [MXW:0]     CAP_M_EXT = (MXW + 1)'(MEMORY_PER_NODE);

    // Control state
    tnfa_pkg::state_t               state_reg, state_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic                           cmp_vld_reg, cmp_vld_next;
    logic                           found_reg, found_next;
    logic [tnfa_pkg::POLICY_W-1:0]  policy_reg;
    logic                           rsp_valid_reg, rsp_valid_next;

    // Payload state
    logic [tnfa_pkg::CORES_W-1:0]   cn_reg, cn_next;
    logic [tnfa_pkg::MEM_W-1:0]     mn_reg, mn_next;
    logic [tnfa_pkg::NODE_W-1:0]    rn_reg, rn_next;
    logic                           rel_ok_reg, rel_ok_next;
    logic [IW-1:0]                  pick_reg, pick_next;
    logic [LW-1:0]                  pick_left_reg, pick_left_next;
    logic [CW-1:0]                  pick_c_reg, pick_c_next;
    logic [MW-1:0]                  pick_m_reg, pick_m_next;
    logic                           granted_reg, granted_next;
    logic [tnfa_pkg::NODE_W-1:0]    node_reg, node_next;
    logic [tnfa_pkg::CORES_W-1:0]   cores_left_reg, cores_left_next;
    logic [tnfa_pkg::MEM_W-1:0]     memory_left_reg, memory_left_next;

    // Node table
    logic [DW-1:0]                  table_mem [NODES];
    logic [DW-1:0]                  rd_data_reg;
    logic                           mem_we;
    logic [IW-1:0]                  mem_waddr;
    logic [DW-1:0]                  mem_wdata;
    logic                           mem_re;
    logic [IW-1:0]                  mem_raddr;

    // Shared compare unit and credit path
    logic [CW-1:0]                  rd_c;
    logic [MW-1:0]                  rd_m;
    logic [CXW-1:0]                 cx, cnx;
    logic [MXW-1:0]                 mx, mnx;
    logic                           fits;
    logic [LW-1:0]                  left;
    logic                           policy_ok;
    logic                           take;
    logic [CXW:0]                   sum_c;
    logic [MXW:0]                   sum_m;
    logic [CW-1:0]                  credit_c;
    logic [MW-1:0]                  credit_m;
    logic [CW-1:0]                  debit_c;
    logic [MW-1:0]                  debit_m;
    logic                           rsp_free;
    logic                           rsp_load;
    logic                           accept;
    logic                           in_range;

    assign req.ready       = (state_reg == tnfa_pkg::ST_IDLE);
    assign accept          = req.valid && req.ready;
    assign rsp_free        = !rsp_valid_reg || rsp.ready;

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.granted     = granted_reg;
    assign rsp.node        = node_reg;
    assign rsp.cores_left  = cores_left_reg;
    assign rsp.memory_left = memory_left_reg;

    assign in_range = (int'(req.release_node) < NODES);

    // ------------------------------------------------------------------
    // Table memory: one write port, one registered read port
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_re)
        begin
            rd_data_reg <= table_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Compare unit
    // ------------------------------------------------------------------
    assign rd_c = rd_data_reg[DW-1:MW];
    assign rd_m = rd_data_reg[MW-1:0];
    assign cx   = CXW'(rd_c);
    assign cnx  = CXW'(cn_reg);
    assign mx   = MXW'(rd_m);
    assign mnx  = MXW'(mn_reg);
    assign fits = (cx >= cnx) && (mx >= mnx);
    assign left = LW'(cx - cnx) + LW'(mx - mnx);

    assign policy_ok = (policy_reg == tnfa_pkg::POL_FIRST)
                    || (policy_reg == tnfa_pkg::POL_BEST)
                    || (policy_reg == tnfa_pkg::POL_WORST);

    // first fit stops updating once a node is held
    assign take = cmp_vld_reg && fits && policy_ok &&
                  (!found_reg
                   || ((policy_reg == tnfa_pkg::POL_BEST)  && (left < pick_left_reg))
                   || ((policy_reg == tnfa_pkg::POL_WORST) && (left > pick_left_reg)));

    // Saturating credit for release
    assign sum_c    = (CXW + 1)'(rd_c) + (CXW + 1)'(cn_reg);
    assign sum_m    = (MXW + 1)'(rd_m) + (MXW + 1)'(mn_reg);
    assign credit_c = (sum_c > CAP_C_EXT) ? FULL_C : CW'(sum_c);
    assign credit_m = (sum_m > CAP_M_EXT) ? FULL_M : MW'(sum_m);

    // Debit of the chosen node; demand is known to fit here
    assign debit_c = pick_c_reg - CW'(cn_reg);
    assign debit_m = pick_m_reg - MW'(mn_reg);

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            tnfa_pkg::ST_CLEAR:
            begin
                if (cnt_reg == CNT_LAST)
                begin
                    state_next = tnfa_pkg::ST_IDLE;
                end
            end
            tnfa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.kind == tnfa_pkg::KIND_RELEASE)
                    begin
                        state_next = tnfa_pkg::ST_REL_RD;
                    end
                    else
                    begin
                        state_next = tnfa_pkg::ST_SCAN;
                    end
                end
            end
            tnfa_pkg::ST_SCAN:
            begin
                if (cnt_reg == CNT_END)
                begin
                    state_next = tnfa_pkg::ST_PICK;
                end
            end
            tnfa_pkg::ST_PICK:
            begin
                if (rsp_free)
                begin
                    state_next = tnfa_pkg::ST_IDLE;
                end
            end
            tnfa_pkg::ST_REL_RD:
            begin
                state_next = tnfa_pkg::ST_REL_WR;
            end
            tnfa_pkg::ST_REL_WR:
            begin
                if (rsp_free)
                begin
                    state_next = tnfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = tnfa_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer outputs: memory ports and response load
    // ------------------------------------------------------------------
    always_comb
    begin
        mem_we           = 1'b0;
        mem_waddr        = cnt_reg[IW-1:0];
        mem_wdata        = {FULL_C, FULL_M};
        mem_re           = 1'b0;
        mem_raddr        = cnt_reg[IW-1:0];
        rsp_load         = 1'b0;
        granted_next     = 1'b0;
        node_next        = '0;
        cores_left_next  = '0;
        memory_left_next = '0;
        unique case (state_reg)
            tnfa_pkg::ST_CLEAR:
            begin
                mem_we = 1'b1;
            end
            tnfa_pkg::ST_IDLE:
            begin
            end
            tnfa_pkg::ST_SCAN:
            begin
                mem_re = (cnt_reg != CNT_END);
            end
            tnfa_pkg::ST_PICK:
            begin
                rsp_load = rsp_free;
                if (found_reg)
                begin
                    mem_we           = rsp_free;
                    mem_waddr        = pick_reg;
                    mem_wdata        = {debit_c, debit_m};
                    granted_next     = 1'b1;
                    node_next        = tnfa_pkg::NODE_W'(pick_reg);
                    cores_left_next  = tnfa_pkg::CORES_W'(debit_c);
                    memory_left_next = tnfa_pkg::MEM_W'(debit_m);
                end
            end
            tnfa_pkg::ST_REL_RD:
            begin
                mem_re    = rel_ok_reg;
                mem_raddr = IW'(rn_reg);
            end
            tnfa_pkg::ST_REL_WR:
            begin
                rsp_load  = rsp_free;
                node_next = rn_reg;
                if (rel_ok_reg)
                begin
                    mem_we           = rsp_free;
                    mem_waddr        = IW'(rn_reg);
                    mem_wdata        = {credit_c, credit_m};
                    granted_next     = 1'b1;
                    cores_left_next  = tnfa_pkg::CORES_W'(credit_c);
                    memory_left_next = tnfa_pkg::MEM_W'(credit_m);
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath next values
    // ------------------------------------------------------------------
    always_comb
    begin
        cnt_next       = cnt_reg;
        cmp_vld_next   = 1'b0;
        found_next     = found_reg;
        pick_next      = pick_reg;
        pick_left_next = pick_left_reg;
        pick_c_next    = pick_c_reg;
        pick_m_next    = pick_m_reg;
        cn_next        = cn_reg;
        mn_next        = mn_reg;
        rn_next        = rn_reg;
        rel_ok_next    = rel_ok_reg;
        rsp_valid_next = rsp_valid_reg;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end

        unique case (state_reg)
            tnfa_pkg::ST_CLEAR:
            begin
                cnt_next = (cnt_reg == CNT_LAST) ? '0 : cnt_reg + 1'b1;
            end
            tnfa_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    cnt_next    = '0;
                    found_next  = 1'b0;
                    cn_next     = req.cores_needed;
                    mn_next     = req.memory_needed;
                    rn_next     = req.release_node;
                    rel_ok_next = in_range;
                end
            end
            tnfa_pkg::ST_SCAN:
            begin
                // issue the next read while the previous entry is compared
                if (cnt_reg != CNT_END)
                begin
                    cnt_next     = cnt_reg + 1'b1;
                    cmp_vld_next = 1'b1;
                end
                if (take)
                begin
                    found_next     = 1'b1;
                    pick_next      = cnt_reg[IW-1:0] - 1'b1;
                    pick_left_next = left;
                    pick_c_next    = rd_c;
                    pick_m_next    = rd_m;
                end
            end
            tnfa_pkg::ST_PICK,
            tnfa_pkg::ST_REL_RD,
            tnfa_pkg::ST_REL_WR:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= tnfa_pkg::ST_CLEAR;
            cnt_reg       <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            policy_reg    <= tnfa_pkg::POL_FIRST;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            cmp_vld_reg   <= cmp_vld_next;
            found_reg     <= found_next;
            rsp_valid_reg <= rsp_valid_next;
            if (cfg_wr_en)
            begin
                policy_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pick_reg      <= pick_next;
        pick_left_reg <= pick_left_next;
        pick_c_reg    <= pick_c_next;
        pick_m_reg    <= pick_m_next;
        cn_reg        <= cn_next;
        mn_reg        <= mn_next;
        rn_reg        <= rn_next;
        rel_ok_reg    <= rel_ok_next;
        if (rsp_load)
        begin
            granted_reg     <= granted_next;
            node_reg        <= node_next;
            cores_left_reg  <= cores_left_next;
            memory_left_reg <= memory_left_next;
        end
    end

endmodule

// ===== verif/tb_two_resource_node_fit_allocator_unit.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_two_resource_node_fit_allocator_unit
// Self-checking bench for the node fit allocator. A scoreboard keeps its own
// copy of the node table and the fit policy, predicts the grant of every
// accepted request and compares it with the response channel. Directed
// corner items come first. Random allocate and release traffic follows under
// each fit policy, with idle bursts on both channels.
// ----------------------------------------------------------------------------
module tb_two_resource_node_fit_allocator_unit;

    localparam int NODE_COUNT = tnfa_pkg::NODES_DEF;
    localparam int CORE_CAP   = tnfa_pkg::CORES_DEF;
    localparam int MEM_CAP    = tnfa_pkg::MEMORY_DEF;

    localparam int K_W = tnfa_pkg::KIND_W;
    localparam int C_W = tnfa_pkg::CORES_W;
    localparam int M_W = tnfa_pkg::MEM_W;
    localparam int N_W = tnfa_pkg::NODE_W;
    localparam int P_W = tnfa_pkg::POLICY_W;

    // Policy code that selects no node
    localparam logic [P_W-1:0] POLICY_NONE = 2'd3;

    typedef struct packed {
        logic [K_W-1:0] kind;
        logic [C_W-1:0] cores;
        logic [M_W-1:0] mem;
        logic [N_W-1:0] node;
    } alloc_req_t;

    typedef struct packed {
        logic           granted;
        logic [N_W-1:0] node;
        logic [C_W-1:0] cores_left;
        logic [M_W-1:0] memory_left;
    } grant_t;

    class alloc_scoreboard;
        logic [C_W-1:0] free_cores [NODE_COUNT];
        logic [M_W-1:0] free_mem [NODE_COUNT];
        logic [P_W-1:0] policy;
        grant_t         grants_due [$];
        int             mismatches;

        function new();
            policy     = tnfa_pkg::POL_FIRST;
            mismatches = 0;
            for (int i = 0; i < NODE_COUNT; i++)
            begin
                free_cores[i] = C_W'(CORE_CAP);
                free_mem[i]   = M_W'(MEM_CAP);
            end
        endfunction

        function void set_policy(logic [P_W-1:0] p);
            policy = p;
        endfunction

        function int pending();
            return grants_due.size();
        endfunction

        function void note_request(alloc_req_t r);
            grant_t g;
            int     c;
            int     m;
            int     left;
            int     pick;
            int     pick_left;
            bit     found;
            g = '0;
            if (r.kind == tnfa_pkg::KIND_RELEASE)
            begin
                if (r.node >= NODE_COUNT)
                begin
                    g.node = r.node;
                end
                else
                begin
                    // credit and clamp at full capacity
                    c = int'(free_cores[r.node]) + int'(r.cores);
                    m = int'(free_mem[r.node]) + int'(r.mem);
                    if (c > CORE_CAP)
                        c = CORE_CAP;
                    if (m > MEM_CAP)
                        m = MEM_CAP;
                    free_cores[r.node] = c[C_W-1:0];
                    free_mem[r.node]   = m[M_W-1:0];
                    g = {1'b1, r.node, c[C_W-1:0], m[M_W-1:0]};
                end
            end
            else
            begin
                found     = 0;
                pick      = 0;
                pick_left = 0;
                if (policy != POLICY_NONE)
                begin
                    for (int i = 0; i < NODE_COUNT; i++)
                    begin
                        if (free_cores[i] < r.cores || free_mem[i] < r.mem)
                            continue;
                        left = (int'(free_cores[i]) - int'(r.cores))
                             + (int'(free_mem[i]) - int'(r.mem));
                        if (!found)
                        begin
                            found     = 1;
                            pick      = i;
                            pick_left = left;
                            if (policy == tnfa_pkg::POL_FIRST)
                                break;
                        end
                        else if (policy == tnfa_pkg::POL_BEST && left < pick_left)
                        begin
                            pick      = i;
                            pick_left = left;
                        end
                        else if (policy == tnfa_pkg::POL_WORST && left > pick_left)
                        begin
                            pick      = i;
                            pick_left = left;
                        end
                    end
                end
                if (found)
                begin
                    free_cores[pick] = free_cores[pick] - r.cores;
                    free_mem[pick]   = free_mem[pick] - r.mem;
                    g = {1'b1, pick[N_W-1:0], free_cores[pick], free_mem[pick]};
                end
            end
            grants_due.insert(grants_due.size(), g);
        endfunction

        function void check_grant(grant_t got);
            grant_t want;
            if (grants_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected grant: granted=%0d node=%0d cores=%0d mem=%0d",
                             got.granted, got.node, got.cores_left, got.memory_left);
                return;
            end
            want = grants_due.pop_front();
            if (got.granted !== want.granted || got.node !== want.node ||
                got.cores_left !== want.cores_left ||
                got.memory_left !== want.memory_left)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("grant mismatch: expected %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                             want.granted, want.node, want.cores_left, want.memory_left,
                             got.granted, got.node, got.cores_left, got.memory_left);
            end
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n;
    logic           cfg_wr_en;
    logic [P_W-1:0] cfg_wr_data;

    tnfa_req_if req_ch ();
    tnfa_rsp_if rsp_ch ();

    two_resource_node_fit_allocator_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    alloc_scoreboard sb = new();

    // 0 means no idling; otherwise an idle burst starts with odds 1 in rate+1
    int send_idle_rate = 0;
    int rsp_stall_rate = 0;
    bit quiet_tail     = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic send_request(alloc_req_t r);
        req_ch.valid         <= 1'b1;
        req_ch.kind          <= r.kind;
        req_ch.cores_needed  <= r.cores;
        req_ch.memory_needed <= r.mem;
        req_ch.release_node  <= r.node;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        sb.note_request(r);
        if (!quiet_tail && send_idle_rate != 0 && $urandom_range(0, send_idle_rate) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
    endtask

    task automatic send_fields(logic [K_W-1:0] k, int c, int m, int n);
        alloc_req_t r;
        r.kind  = k;
        r.cores = C_W'(c);
        r.mem   = M_W'(m);
        r.node  = N_W'(n);
        send_request(r);
    endtask

    task automatic set_fit_policy(logic [P_W-1:0] p);
        // hold off until every grant is back and the block is idle
        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= p;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.set_policy(p);
    endtask

    function automatic alloc_req_t random_request();
        alloc_req_t r;
        int         sel;
        r.node = N_W'($urandom_range(0, 127));
        if ($urandom_range(0, 99) < 35)
        begin
            r.kind = tnfa_pkg::KIND_RELEASE;
            if ($urandom_range(0, 9) < 7)
            begin
                // small returns keep the pool partly drained
                r.cores = C_W'($urandom_range(0, 8));
                r.mem   = M_W'($urandom_range(0, 20));
                if ($urandom_range(0, 1) == 1)
                    r.node = N_W'($urandom_range(0, 7));
            end
            else
            begin
                r.cores = C_W'($urandom_range(0, 31));
                r.mem   = M_W'($urandom_range(0, 127));
            end
        end
        else
        begin
            r.kind = tnfa_pkg::KIND_ALLOC;
            sel    = $urandom_range(0, 99);
            if (sel < 8)
            begin
                r.cores = C_W'($urandom_range(25, 31));
                r.mem   = M_W'($urandom_range(0, 127));
            end
            else if (sel < 16)
            begin
                r.cores = C_W'($urandom_range(0, 31));
                r.mem   = M_W'($urandom_range(65, 127));
            end
            else
            begin
                r.cores = C_W'($urandom_range(0, 24));
                r.mem   = M_W'($urandom_range(0, 64));
            end
        end
        return r;
    endfunction

    // response side: check accepted grants, stall in random bursts
    initial
    begin
        int     stall_left;
        grant_t got;
        stall_left   = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
            begin
                got.granted     = rsp_ch.granted;
                got.node        = rsp_ch.node;
                got.cores_left  = rsp_ch.cores_left;
                got.memory_left = rsp_ch.memory_left;
                sb.check_grant(got);
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else if (!quiet_tail && rsp_stall_rate != 0 &&
                     $urandom_range(0, rsp_stall_rate) == 0)
            begin
                stall_left = $urandom_range(1, 9) - 1;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        logic [P_W-1:0] phase_policy [8];
        int             phase_len;
        phase_policy = '{tnfa_pkg::POL_BEST, tnfa_pkg::POL_WORST, tnfa_pkg::POL_FIRST,
                         POLICY_NONE, tnfa_pkg::POL_WORST, tnfa_pkg::POL_BEST,
                         tnfa_pkg::POL_FIRST, tnfa_pkg::POL_BEST};
        rst_n                <= 1'b0;
        cfg_wr_en            <= 1'b0;
        cfg_wr_data          <= '0;
        req_ch.valid         <= 1'b0;
        req_ch.kind          <= tnfa_pkg::KIND_ALLOC;
        req_ch.cores_needed  <= '0;
        req_ch.memory_needed <= '0;
        req_ch.release_node  <= '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // first fit from reset: zero demand, full node, oversize demand, releases
        send_request_block: begin
            send_fields(tnfa_pkg::KIND_ALLOC, 0, 0, 127);
            send_fields(tnfa_pkg::KIND_ALLOC, 24, 64, 0);
            send_fields(tnfa_pkg::KIND_ALLOC, 24, 64, 5);
            send_fields(tnfa_pkg::KIND_ALLOC, 31, 127, 127);
            send_fields(tnfa_pkg::KIND_ALLOC, 25, 0, 0);
            send_fields(tnfa_pkg::KIND_ALLOC, 0, 65, 0);
            send_fields(tnfa_pkg::KIND_ALLOC, 0, 0, 0);
            send_fields(tnfa_pkg::KIND_RELEASE, 31, 127, 0);
            send_fields(tnfa_pkg::KIND_RELEASE, 0, 0, 127);
            send_fields(tnfa_pkg::KIND_RELEASE, 1, 1, 1);
            send_fields(tnfa_pkg::KIND_ALLOC, 1, 1, 64);
        end

        // best fit takes the exact fit; worst fit takes the emptiest node; the fourth code grants nothing
        set_fit_policy(tnfa_pkg::POL_BEST);
        send_fields(tnfa_pkg::KIND_ALLOC, 1, 1, 0);
        send_fields(tnfa_pkg::KIND_ALLOC, 0, 0, 0);
        set_fit_policy(tnfa_pkg::POL_WORST);
        send_fields(tnfa_pkg::KIND_ALLOC, 0, 0, 0);
        send_fields(tnfa_pkg::KIND_ALLOC, 24, 64, 0);
        set_fit_policy(POLICY_NONE);
        send_fields(tnfa_pkg::KIND_ALLOC, 0, 0, 0);
        send_fields(tnfa_pkg::KIND_RELEASE, 31, 127, 5);

        for (int ph = 0; ph < 8; ph++)
        begin
            set_fit_policy(phase_policy[ph]);
            phase_len = (phase_policy[ph] == POLICY_NONE) ? 60 : 195;
            if (ph == 7)
                quiet_tail = 1;
            for (int n = 0; n < phase_len; n++)
            begin
                if (n % 40 == 0)
                begin
                    send_idle_rate = $urandom_range(0, 3) * 3;
                    rsp_stall_rate = $urandom_range(0, 3) * 3;
                end
                send_request(random_request());
            end
        end

        req_ch.valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (NODE_COUNT + 8) @(posedge clk);
        if (sb.mismatches == 0)
            $display("[two_resource_node_fit_allocator_unit] OK");
        else
            $display("[two_resource_node_fit_allocator_unit] ERROR");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("[two_resource_node_fit_allocator_unit] ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tnfa_pkg.sv
src/tnfa_req_if.sv
src/tnfa_rsp_if.sv
src/two_resource_node_fit_allocator_unit.sv
verif/tb_two_resource_node_fit_allocator_unit.sv
